### rtl/core/assert_macros.svh
// assertion macros for the tracker, sampled on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every edge out of reset
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tracker assertion failed");
// condition must never be seen at an edge out of reset
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("tracker forbidden condition");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, cond)
`endif
`endif

### rtl/core/ptst_pkg.sv
package ptst_pkg;

	// field widths
	localparam int PULSE_W    = 12;
	localparam int SAMPLE_W   = 12;
	localparam int COUNT_W    = 24;
	localparam int DB_W       = 9;
	localparam int DIVR_W     = 6;
	localparam int MAG_W      = 10;
	localparam int OFS_W      = 9;
	localparam int DEC_W      = 16;
	localparam int VOLT_W     = 18;
	localparam int RECIP_W    = 18;
	localparam int DIST_W     = 20;
	localparam int CLAMP_W    = 19;
	localparam int CHAR_W     = 8;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

	// opcodes
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_RANGE = 2'd1;
	localparam logic [OP_W-1:0] OP_MSG   = 2'd2;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_CENTER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAN_CENTER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_MIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAN_MIN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PAN_MAX     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 3'd7;

	// register reset values
	localparam logic [PULSE_W-1:0] RST_TILT_CENTER = 12'd320;
	localparam logic [PULSE_W-1:0] RST_PAN_CENTER  = 12'd250;
	localparam logic [PULSE_W-1:0] RST_TILT_MIN    = 12'd300;
	localparam logic [PULSE_W-1:0] RST_TILT_MAX    = 12'd340;
	localparam logic [PULSE_W-1:0] RST_PAN_MIN     = 12'd180;
	localparam logic [PULSE_W-1:0] RST_PAN_MAX     = 12'd320;
	localparam logic [COUNT_W-1:0] RST_TIMEOUT     = 24'd200000;
	localparam logic [DB_W-1:0]    RST_DEADBAND    = 9'd10;
	localparam logic [DIVR_W-1:0]  RST_TILT_DIVR   = 6'd9;
	localparam logic [DIVR_W-1:0]  RST_PAN_DIVR    = 6'd6;

	// range fit constants, 16 fraction bits
	localparam logic [VOLT_W-1:0]  Q_VOLT_SCALE = 18'd216269;
	localparam logic [VOLT_W-1:0]  Q_KNEE       = 18'd90964;
	localparam logic [CLAMP_W-1:0] Q_NEAR_OFS   = 19'd293025;
	localparam logic [RECIP_W-1:0] Q_NEAR_RECIP = 18'd41989;
	localparam logic [CLAMP_W-1:0] Q_FAR_OFS    = 19'd140542;
	localparam logic [RECIP_W-1:0] Q_FAR_RECIP  = 18'd171157;
	localparam logic [CLAMP_W-1:0] Q_ONE        = 19'd65536;
	localparam logic [CLAMP_W-1:0] Q_SIX        = 19'd393216;

	// offset message constants
	localparam logic [CHAR_W-1:0] CHAR_RIGHT = 8'h72;
	localparam logic [CHAR_W-1:0] CHAR_UP    = 8'h75;
	localparam logic [OFS_W-1:0]  OFFSET_CAP = 9'd500;
	localparam logic [MAG_W:0]    TILT_BIAS  = 11'd100;

	typedef struct packed {
		logic [OP_W-1:0]     opcode;
		logic [SAMPLE_W-1:0] range_sample;
		logic [CHAR_W-1:0]   pan_dir_char;
		logic [CHAR_W-1:0]   pan_hundreds;
		logic [CHAR_W-1:0]   pan_tens;
		logic [CHAR_W-1:0]   pan_units;
		logic [CHAR_W-1:0]   tilt_dir_char;
		logic [CHAR_W-1:0]   tilt_hundreds;
		logic [CHAR_W-1:0]   tilt_tens;
		logic [CHAR_W-1:0]   tilt_units;
	} item_t;

	typedef struct packed {
		logic [PULSE_W-1:0] tilt_pulse;
		logic [PULSE_W-1:0] pan_pulse;
		logic               recentered;
	} result_t;

	typedef struct packed {
		logic                  en;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic tick;
		logic rng_volt;
		logic rng_dist;
		logic rng_divr;
		logic msg_start;
		logic apply;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] opcode;
		logic            div_busy;
	} status_t;

endpackage

### rtl/core/ptst_in_if.sv
interface ptst_in_if;
	import ptst_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [SAMPLE_W-1:0] range_sample;
	logic [CHAR_W-1:0]   pan_dir_char;
	logic [CHAR_W-1:0]   pan_hundreds;
	logic [CHAR_W-1:0]   pan_tens;
	logic [CHAR_W-1:0]   pan_units;
	logic [CHAR_W-1:0]   tilt_dir_char;
	logic [CHAR_W-1:0]   tilt_hundreds;
	logic [CHAR_W-1:0]   tilt_tens;
	logic [CHAR_W-1:0]   tilt_units;

	modport source (
		output valid, opcode, range_sample, pan_dir_char, pan_hundreds, pan_tens,
			pan_units, tilt_dir_char, tilt_hundreds, tilt_tens, tilt_units,
		input ready
	);
	modport sink (
		input valid, opcode, range_sample, pan_dir_char, pan_hundreds, pan_tens,
			pan_units, tilt_dir_char, tilt_hundreds, tilt_tens, tilt_units,
		output ready
	);
endinterface

### rtl/core/ptst_out_if.sv
interface ptst_out_if;
	import ptst_pkg::*;

	logic               valid;
	logic               ready;
	logic [PULSE_W-1:0] tilt_pulse;
	logic [PULSE_W-1:0] pan_pulse;
	logic               recentered;

	modport source (output valid, tilt_pulse, pan_pulse, recentered, input ready);
	modport sink (input valid, tilt_pulse, pan_pulse, recentered, output ready);
endinterface

### rtl/core/ptst_cfg_if.sv
interface ptst_cfg_if;
	import ptst_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/ptst_div.sv
module ptst_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ptst_pkg::MAG_W-1:0]    dividend,
	input  logic [ptst_pkg::DIVR_W-1:0]   divisor,
	output logic                          busy,
	output logic [ptst_pkg::MAG_W-1:0]    quotient
);
	import ptst_pkg::*;

	logic [DIVR_W-1:0]    rem_q;
	logic [MAG_W-1:0]     quo_q;
	logic [DIVR_W-1:0]    divr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DIVR_W:0]      shifted;
	logic [DIVR_W+1:0]    trial;
	logic                 fits;

	// one restoring step: shift in the next dividend bit, try the subtract
	always_comb begin
		shifted = {rem_q, quo_q[MAG_W-1]};
		trial   = {1'b0, shifted} - {2'b00, divr_q};
		fits    = !trial[DIVR_W+1];
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(MAG_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			divr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DIVR_W-1:0] : shifted[DIVR_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule

### rtl/core/ptst_dp.sv
module ptst_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ptst_pkg::cmd_t    cmd,
	input  ptst_pkg::item_t   item,
	input  ptst_pkg::cfg_wr_t cfg_wr,
	output ptst_pkg::status_t status,
	output ptst_pkg::result_t result
);
	import ptst_pkg::*;

	// ascii offset decode with deadband and cap, magnitude only
	function automatic logic [OFS_W-1:0] decode_offset(
		input logic [CHAR_W-1:0] h,
		input logic [CHAR_W-1:0] t,
		input logic [CHAR_W-1:0] u,
		input logic [DB_W-1:0]   db
	);
		logic signed [DEC_W-1:0] v;
		logic [OFS_W-1:0]        r;
		v = ($signed({8'b0, h}) - 16'sd48) * 16'sd100
			+ ($signed({8'b0, t}) - 16'sd48) * 16'sd10
			+ ($signed({8'b0, u}) - 16'sd48);
		if (v < $signed({7'b0, db}))
			r = '0;
		else if (v > $signed({7'b0, OFFSET_CAP}))
			r = OFFSET_CAP;
		else
			r = v[OFS_W-1:0];
		return r;
	endfunction

	// add a signed step to a pulse, clamp to max then to min
	function automatic logic [PULSE_W-1:0] move_pulse(
		input logic [PULSE_W-1:0] pulse,
		input logic [MAG_W-1:0]   quo,
		input logic               neg,
		input logic [PULSE_W-1:0] lo,
		input logic [PULSE_W-1:0] hi
	);
		logic signed [PULSE_W+1:0] step;
		logic signed [PULSE_W+1:0] sum;
		step = $signed({{(PULSE_W+2-MAG_W){1'b0}}, quo});
		if (neg)
			step = -step;
		sum = $signed({2'b00, pulse}) + step;
		if (sum > $signed({2'b00, hi}))
			sum = $signed({2'b00, hi});
		if (sum < $signed({2'b00, lo}))
			sum = $signed({2'b00, lo});
		return sum[PULSE_W-1:0];
	endfunction

	item_t               item_q;
	logic [PULSE_W-1:0]  tilt_center_q, pan_center_q;
	logic [PULSE_W-1:0]  tilt_min_q, tilt_max_q, pan_min_q, pan_max_q;
	logic [COUNT_W-1:0]  timeout_q;
	logic [DB_W-1:0]     deadband_q;
	logic [PULSE_W-1:0]  tilt_width_q, pan_width_q;
	logic [COUNT_W-1:0]  idle_q;
	logic [DIVR_W-1:0]   tilt_divr_q, pan_divr_q;
	logic                flag_q;
	logic                tilt_neg_q, pan_neg_q;
	logic [VOLT_W-1:0]   volt_s1;
	logic [DIST_W-1:0]   dist_s2;
	result_t             result_q;

	logic [SAMPLE_W+VOLT_W-1:0]  volt_prod;
	logic                        near;
	logic [CLAMP_W-1:0]          diff_wide;
	logic [RECIP_W-1:0]          recip;
	logic [VOLT_W+RECIP_W-1:0]   dist_prod;
	logic [CLAMP_W-1:0]          dist_c;
	logic [CLAMP_W+3:0]          tilt_scaled;
	logic [CLAMP_W+2:0]          pan_scaled;
	logic [OFS_W-1:0]            tilt_ofs, pan_ofs;
	logic signed [MAG_W:0]       tilt_off, tilt_off_neg;
	logic [MAG_W-1:0]            tilt_mag, pan_mag;
	logic                        tilt_neg, pan_neg;
	logic [DIVR_W-1:0]           tilt_divr_eff, pan_divr_eff;
	logic                        tilt_busy, pan_busy;
	logic [MAG_W-1:0]            tilt_quo, pan_quo;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load_item)
			item_q <= item;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_center_q <= RST_TILT_CENTER;
			pan_center_q  <= RST_PAN_CENTER;
			tilt_min_q    <= RST_TILT_MIN;
			tilt_max_q    <= RST_TILT_MAX;
			pan_min_q     <= RST_PAN_MIN;
			pan_max_q     <= RST_PAN_MAX;
			timeout_q     <= RST_TIMEOUT;
			deadband_q    <= RST_DEADBAND;
		end else if (cfg_wr.en) begin
			unique case (cfg_wr.index)
				CFG_TILT_CENTER: tilt_center_q <= cfg_wr.data[PULSE_W-1:0];
				CFG_PAN_CENTER:  pan_center_q  <= cfg_wr.data[PULSE_W-1:0];
				CFG_TILT_MIN:    tilt_min_q    <= cfg_wr.data[PULSE_W-1:0];
				CFG_TILT_MAX:    tilt_max_q    <= cfg_wr.data[PULSE_W-1:0];
				CFG_PAN_MIN:     pan_min_q     <= cfg_wr.data[PULSE_W-1:0];
				CFG_PAN_MAX:     pan_max_q     <= cfg_wr.data[PULSE_W-1:0];
				CFG_TIMEOUT:     timeout_q     <= cfg_wr.data[COUNT_W-1:0];
				CFG_DEADBAND:    deadband_q    <= cfg_wr.data[DB_W-1:0];
				default: ;
			endcase
		end
	end

	// range fit: voltage stage, then distance stage
	always_comb begin
		volt_prod = item_q.range_sample * Q_VOLT_SCALE;
		near      = volt_s1 > Q_KNEE;
		diff_wide = near ? (Q_NEAR_OFS - {1'b0, volt_s1}) : (Q_FAR_OFS - {1'b0, volt_s1});
		recip     = near ? Q_NEAR_RECIP : Q_FAR_RECIP;
		dist_prod = diff_wide[VOLT_W-1:0] * recip;
	end

	always_ff @(posedge clk) begin
		if (cmd.rng_volt)
			volt_s1 <= volt_prod[SAMPLE_W +: VOLT_W];
		if (cmd.rng_dist)
			dist_s2 <= dist_prod[16 +: DIST_W];
	end

	// clamp distance to 1..6 and scale to divisors by shift and add
	always_comb begin
		if (dist_s2 < DIST_W'(Q_ONE))
			dist_c = Q_ONE;
		else if (dist_s2 > DIST_W'(Q_SIX))
			dist_c = Q_SIX;
		else
			dist_c = dist_s2[CLAMP_W-1:0];
		tilt_scaled = {1'b0, dist_c, 3'b000} + {4'b0000, dist_c};
		pan_scaled  = {1'b0, dist_c, 2'b00} + {2'b00, dist_c, 1'b0};
	end

	// offset decode for both axes, tilt gets its bias
	always_comb begin
		pan_ofs  = decode_offset(item_q.pan_hundreds, item_q.pan_tens, item_q.pan_units,
			deadband_q);
		tilt_ofs = decode_offset(item_q.tilt_hundreds, item_q.tilt_tens, item_q.tilt_units,
			deadband_q);
		pan_neg  = item_q.pan_dir_char == CHAR_RIGHT;
		pan_mag  = {1'b0, pan_ofs};
		tilt_off = $signed({2'b00, tilt_ofs});
		if (item_q.tilt_dir_char == CHAR_UP)
			tilt_off = -tilt_off;
		tilt_off     = tilt_off + $signed(TILT_BIAS);
		tilt_off_neg = -tilt_off;
		tilt_neg     = tilt_off[MAG_W];
		tilt_mag     = tilt_neg ? tilt_off_neg[MAG_W-1:0] : tilt_off[MAG_W-1:0];
		tilt_divr_eff = (tilt_divr_q == '0) ? DIVR_W'(1) : tilt_divr_q;
		pan_divr_eff  = (pan_divr_q == '0) ? DIVR_W'(1) : pan_divr_q;
	end

	// one divider lane per axis
	ptst_div u_tilt_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.msg_start),
		.dividend (tilt_mag),
		.divisor  (tilt_divr_eff),
		.busy     (tilt_busy),
		.quotient (tilt_quo)
	);

	ptst_div u_pan_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.msg_start),
		.dividend (pan_mag),
		.divisor  (pan_divr_eff),
		.busy     (pan_busy),
		.quotient (pan_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.msg_start) begin
			tilt_neg_q <= tilt_neg;
			pan_neg_q  <= pan_neg;
		end
	end

	// servo state: pulses, idle counter, divisors, recenter flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_width_q <= RST_TILT_CENTER;
			pan_width_q  <= RST_PAN_CENTER;
			idle_q       <= '0;
			tilt_divr_q  <= RST_TILT_DIVR;
			pan_divr_q   <= RST_PAN_DIVR;
			flag_q       <= 1'b0;
		end else begin
			if (cmd.load_item)
				flag_q <= 1'b0;
			if (cmd.tick) begin
				if (idle_q > timeout_q) begin
					tilt_width_q <= tilt_center_q;
					pan_width_q  <= pan_center_q;
					idle_q       <= COUNT_W'(1);
					flag_q       <= 1'b1;
				end else if (idle_q != '1) begin
					idle_q <= idle_q + 1'b1;
				end
			end
			if (cmd.rng_divr) begin
				tilt_divr_q <= tilt_scaled[16 +: DIVR_W];
				pan_divr_q  <= pan_scaled[16 +: DIVR_W];
			end
			if (cmd.msg_start)
				idle_q <= '0;
			if (cmd.apply) begin
				tilt_width_q <= move_pulse(tilt_width_q, tilt_quo, tilt_neg_q, tilt_min_q,
					tilt_max_q);
				pan_width_q  <= move_pulse(pan_width_q, pan_quo, pan_neg_q, pan_min_q,
					pan_max_q);
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.tilt_pulse <= tilt_width_q;
			result_q.pan_pulse  <= pan_width_q;
			result_q.recentered <= flag_q;
		end
	end

	assign result          = result_q;
	assign status.opcode   = item_q.opcode;
	assign status.div_busy = tilt_busy | pan_busy;
endmodule

### rtl/core/ptst_ctrl.sv
module ptst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ptst_pkg::status_t status,
	output ptst_pkg::cmd_t    cmd
);
	import ptst_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_EXEC     = 3'd1;
	localparam logic [2:0] S_RNG_D    = 3'd2;
	localparam logic [2:0] S_RNG_DIV  = 3'd3;
	localparam logic [2:0] S_DIV_WAIT = 3'd4;
	localparam logic [2:0] S_APPLY    = 3'd5;
	localparam logic [2:0] S_FINISH   = 3'd6;

	logic [2:0] state_q, state_next;
	logic       out_valid_q;

	// sequencer
	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_next    = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (status.opcode)
					OP_TICK: begin
						cmd.tick   = 1'b1;
						state_next = S_FINISH;
					end
					OP_RANGE: begin
						cmd.rng_volt = 1'b1;
						state_next   = S_RNG_D;
					end
					OP_MSG: begin
						cmd.msg_start = 1'b1;
						state_next    = S_DIV_WAIT;
					end
					default: state_next = S_FINISH;
				endcase
			end
			S_RNG_D: begin
				cmd.rng_dist = 1'b1;
				state_next   = S_RNG_DIV;
			end
			S_RNG_DIV: begin
				cmd.rng_divr = 1'b1;
				state_next   = S_FINISH;
			end
			S_DIV_WAIT: begin
				if (!status.div_busy)
					state_next = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply  = 1'b1;
				state_next = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_next   = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_next;
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
endmodule

### rtl/core/pan_tilt_servo_tracker_top.sv
// Pan-tilt servo tracker. Each request carries an opcode: a tick advances the idle
// counter and recenters both servos once it has passed timeout_ticks; a range
// sample is mapped to a distance that sets the pan and tilt step divisors; an
// offset message moves both pulses by their decoded offsets divided by those
// divisors, clamped to the configured limits. Every request yields one result
// with both pulse widths and a recenter flag. Requests are handled one at a time:
// a tick updates the idle counter, a range sample passes the two multiplier stages
// (voltage and distance) and the divisor scaling, and an offset message waits on the
// two divider lanes that retire one quotient bit per cycle over ten steps. A new
// request is taken while the previous result still waits in the output register.
// Configuration writes are always accepted and belong in idle periods.
module pan_tilt_servo_tracker_top (
	input logic        clk,
	input logic        arst_n,
	ptst_in_if.sink    in_ch,
	ptst_out_if.source out_ch,
	ptst_cfg_if.sink   cfg
);
	import ptst_pkg::*;

	cmd_t    cmd;
	status_t dp_status;
	item_t   in_item;
	cfg_wr_t cfg_wr;
	result_t result;
	logic    in_ready;
	logic    out_valid;

	// pack channel payloads
	assign in_item = '{
		opcode:        in_ch.opcode,
		range_sample:  in_ch.range_sample,
		pan_dir_char:  in_ch.pan_dir_char,
		pan_hundreds:  in_ch.pan_hundreds,
		pan_tens:      in_ch.pan_tens,
		pan_units:     in_ch.pan_units,
		tilt_dir_char: in_ch.tilt_dir_char,
		tilt_hundreds: in_ch.tilt_hundreds,
		tilt_tens:     in_ch.tilt_tens,
		tilt_units:    in_ch.tilt_units
	};
	assign cfg_wr = '{en: cfg.valid, index: cfg.index, data: cfg.data};
	assign cfg.ready = 1'b1;

	ptst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.status    (dp_status),
		.cmd       (cmd)
	);

	ptst_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (in_item),
		.cfg_wr (cfg_wr),
		.status (dp_status),
		.result (result)
	);

	// drive channels
	assign in_ch.ready       = in_ready;
	assign out_ch.valid      = out_valid;
	assign out_ch.tilt_pulse = result.tilt_pulse;
	assign out_ch.pan_pulse  = result.pan_pulse;
	assign out_ch.recentered = result.recentered;

	`include "assert_macros.svh"

	// dividers start the cycle after a message is dispatched
	`ASSERT_CLK(a_div_starts, cmd.msg_start |=> dp_status.div_busy)
	// a loaded result is always presented
	`ASSERT_CLK(a_load_presents, cmd.out_load |=> out_ch.valid)
	// no request taken while a division is in flight
	`ASSERT_NEVER(a_no_accept_in_div, in_ch.ready && dp_status.div_busy)
endmodule

### verif/tb_pan_tilt_servo_tracker_top.sv
`timescale 1ns / 1ps

module tb_pan_tilt_servo_tracker_top;
	import ptst_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS = 230;
	localparam int ITEM_W = $bits(item_t);
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	// range fit in 16-bit fraction fixed point
	localparam longint unsigned VOLT_GAIN = 216269;
	localparam longint unsigned KNEE_V = 90964;
	localparam longint unsigned NEAR_INTERCEPT = 293025;
	localparam longint unsigned NEAR_SLOPE = 41989;
	localparam longint unsigned FAR_INTERCEPT = 140542;
	localparam longint unsigned FAR_SLOPE = 171157;
	localparam longint unsigned ONE_Q16 = 65536;
	localparam int OFFSET_LIMIT = 500;
	localparam int TILT_LIFT = 100;
	localparam logic [COUNT_W-1:0] IDLE_SAT = 24'hFFFFFF;

	logic clk;
	logic arst_n;

	ptst_in_if in_ch ();
	ptst_out_if out_ch ();
	ptst_cfg_if cfg_ch ();

	pan_tilt_servo_tracker_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	always #2 clk = ~clk;

	// tracker registers as the block should hold them
	logic [PULSE_W-1:0] tilt_center_r, pan_center_r, tilt_min_r, tilt_max_r;
	logic [PULSE_W-1:0] pan_min_r, pan_max_r;
	logic [COUNT_W-1:0] timeout_r;
	logic [DB_W-1:0]    deadband_r;

	// tracker state
	logic [PULSE_W-1:0] tilt_now, pan_now;
	logic [COUNT_W-1:0] idle_ticks;
	int                 tilt_step_div, pan_step_div;

	item_t   request_backlog[$];
	result_t expected_pulses[$];
	item_t   on_wire;
	int      gap_left;
	int      stall_left;
	int      mismatches;
	int      cycles;
	bit      calm;

	// decoded offset magnitude after deadband and cap
	function automatic int offset_value(logic [7:0] h, logic [7:0] t, logic [7:0] u);
		int hv, tv, uv, dbv, v;
		hv = h;
		tv = t;
		uv = u;
		dbv = deadband_r;
		v = (hv - 48) * 100 + (tv - 48) * 10 + (uv - 48);
		if (v < dbv)
			v = 0;
		if (v > OFFSET_LIMIT)
			v = OFFSET_LIMIT;
		return v;
	endfunction

	// pulse plus truncated step, clamped to max then min then zero
	function automatic logic [PULSE_W-1:0] moved_pulse(logic [PULSE_W-1:0] pulse, int ofs,
			int divr, logic [PULSE_W-1:0] lo, logic [PULSE_W-1:0] hi);
		int s, lov, hiv;
		lov = lo;
		hiv = hi;
		s = pulse;
		s = s + ofs / ((divr == 0) ? 1 : divr);
		if (s > hiv)
			s = hiv;
		if (s < lov)
			s = lov;
		if (s < 0)
			s = 0;
		return s[PULSE_W-1:0];
	endfunction

	// advance the tracker by one request and return the pulses it reports
	function automatic result_t servo_step(item_t it);
		result_t          res;
		longint unsigned  smp, volts, span;
		int               pan_ofs, tilt_ofs;
		res.recentered = 1'b0;
		case (it.opcode)
			OP_TICK: begin
				if (idle_ticks > timeout_r) begin
					tilt_now = tilt_center_r;
					pan_now = pan_center_r;
					idle_ticks = '0;
					res.recentered = 1'b1;
				end
				if (idle_ticks != IDLE_SAT)
					idle_ticks = idle_ticks + 1'b1;
			end
			OP_RANGE: begin
				smp = it.range_sample;
				volts = (smp * VOLT_GAIN) >> SAMPLE_W;
				if (volts > KNEE_V)
					span = ((NEAR_INTERCEPT - volts) * NEAR_SLOPE) >> 16;
				else
					span = ((FAR_INTERCEPT - volts) * FAR_SLOPE) >> 16;
				if (span < ONE_Q16)
					span = ONE_Q16;
				if (span > 6 * ONE_Q16)
					span = 6 * ONE_Q16;
				tilt_step_div = int'((9 * span) >> 16);
				pan_step_div = int'((6 * span) >> 16);
			end
			OP_MSG: begin
				idle_ticks = '0;
				pan_ofs = offset_value(it.pan_hundreds, it.pan_tens, it.pan_units);
				if (it.pan_dir_char == CHAR_RIGHT)
					pan_ofs = -pan_ofs;
				tilt_ofs = offset_value(it.tilt_hundreds, it.tilt_tens, it.tilt_units);
				if (it.tilt_dir_char == CHAR_UP)
					tilt_ofs = -tilt_ofs;
				tilt_ofs = tilt_ofs + TILT_LIFT;
				tilt_now = moved_pulse(tilt_now, tilt_ofs, tilt_step_div, tilt_min_r, tilt_max_r);
				pan_now = moved_pulse(pan_now, pan_ofs, pan_step_div, pan_min_r, pan_max_r);
			end
			default: begin
			end
		endcase
		res.tilt_pulse = tilt_now;
		res.pan_pulse = pan_now;
		return res;
	endfunction

	// mostly short gaps, a few long ones, none in calm stretches
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				expected_pulses.push_back(servo_step(on_wire));
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (request_backlog.size() != 0) begin
					on_wire = request_backlog.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.opcode <= on_wire.opcode;
					in_ch.range_sample <= on_wire.range_sample;
					in_ch.pan_dir_char <= on_wire.pan_dir_char;
					in_ch.pan_hundreds <= on_wire.pan_hundreds;
					in_ch.pan_tens <= on_wire.pan_tens;
					in_ch.pan_units <= on_wire.pan_units;
					in_ch.tilt_dir_char <= on_wire.tilt_dir_char;
					in_ch.tilt_hundreds <= on_wire.tilt_hundreds;
					in_ch.tilt_tens <= on_wire.tilt_tens;
					in_ch.tilt_units <= on_wire.tilt_units;
					gap_left = idle_len();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// result monitor with random back-pressure
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_pulses.size() == 0) begin
					$display("%0t: unexpected result expected none actual %0d %0d %0d", $time,
						out_ch.tilt_pulse, out_ch.pan_pulse, out_ch.recentered);
					mismatches++;
				end else begin
					want = expected_pulses.pop_front();
					check_field("tilt_pulse", want.tilt_pulse, out_ch.tilt_pulse);
					check_field("pan_pulse", want.pan_pulse, out_ch.pan_pulse);
					check_field("recentered", want.recentered, out_ch.recentered);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= CFG_DATA_W'(val);
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_TILT_CENTER: tilt_center_r = val[PULSE_W-1:0];
			CFG_PAN_CENTER:  pan_center_r = val[PULSE_W-1:0];
			CFG_TILT_MIN:    tilt_min_r = val[PULSE_W-1:0];
			CFG_TILT_MAX:    tilt_max_r = val[PULSE_W-1:0];
			CFG_PAN_MIN:     pan_min_r = val[PULSE_W-1:0];
			CFG_PAN_MAX:     pan_max_r = val[PULSE_W-1:0];
			CFG_TIMEOUT:     timeout_r = val[COUNT_W-1:0];
			CFG_DEADBAND:    deadband_r = val[DB_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic set_regs(int tc, int pc, int tmin, int tmax, int pmin, int pmax,
			int tout, int db);
		write_reg(CFG_TILT_CENTER, tc);
		write_reg(CFG_PAN_CENTER, pc);
		write_reg(CFG_TILT_MIN, tmin);
		write_reg(CFG_TILT_MAX, tmax);
		write_reg(CFG_PAN_MIN, pmin);
		write_reg(CFG_PAN_MAX, pmax);
		write_reg(CFG_TIMEOUT, tout);
		write_reg(CFG_DEADBAND, db);
	endtask

	// random limits around a random center, min above max now and then
	task automatic set_random_regs(int db_top);
		int tmin, pmin, tmax, pmax;
		tmin = $urandom_range(0, 4000);
		pmin = $urandom_range(0, 4000);
		tmax = tmin + $urandom_range(0, 95);
		pmax = pmin + $urandom_range(0, 95);
		if ($urandom_range(0, 4) == 0)
			tmax = $urandom_range(0, 4095);
		set_regs(tmin + $urandom_range(0, 95), pmin + $urandom_range(0, 95), tmin, tmax,
			pmin, pmax, $urandom_range(0, 20), $urandom_range(0, db_top));
	endtask

	task automatic settle();
		while (request_backlog.size() != 0 || in_ch.valid || expected_pulses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic item_t any_request(logic [OP_W-1:0] op);
		item_t it;
		it = ITEM_W'({$urandom(), $urandom(), $urandom()});
		it.opcode = op;
		return it;
	endfunction

	// offset message from eight characters: pan dir, 3 digits, tilt dir, 3 digits
	function automatic item_t msg_of(string m);
		item_t it;
		it = any_request(OP_MSG);
		it.pan_dir_char = m[0];
		it.pan_hundreds = m[1];
		it.pan_tens = m[2];
		it.pan_units = m[3];
		it.tilt_dir_char = m[4];
		it.tilt_hundreds = m[5];
		it.tilt_tens = m[6];
		it.tilt_units = m[7];
		return it;
	endfunction

	function automatic item_t range_of(int sample);
		item_t it;
		it = any_request(OP_RANGE);
		it.range_sample = SAMPLE_W'(sample);
		return it;
	endfunction

	// mostly well-formed messages, the rest raw bytes
	function automatic item_t random_msg();
		item_t it;
		it = any_request(OP_MSG);
		if ($urandom_range(0, 9) != 0) begin
			if ($urandom_range(0, 5) != 0)
				it.pan_dir_char = $urandom_range(0, 1) ? CHAR_RIGHT : "l";
			if ($urandom_range(0, 5) != 0)
				it.tilt_dir_char = $urandom_range(0, 1) ? CHAR_UP : "d";
			it.pan_hundreds = CHAR_W'("0" +
				(($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0));
			it.pan_tens = CHAR_W'("0" + $urandom_range(0, 9));
			it.pan_units = CHAR_W'("0" + $urandom_range(0, 9));
			it.tilt_hundreds = CHAR_W'("0" +
				(($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0));
			it.tilt_tens = CHAR_W'("0" + $urandom_range(0, 9));
			it.tilt_units = CHAR_W'("0" + $urandom_range(0, 9));
		end
		return it;
	endfunction

	task automatic queue_random(int n);
		int k, r, len, top;
		k = 0;
		while (k < n) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				// tick runs long enough to pass small timeouts
				top = (timeout_r < 30) ? int'(timeout_r) + 4 : 6;
				len = $urandom_range(1, top);
				repeat (len) request_backlog.push_back(any_request(OP_TICK));
				k += len;
			end else if (r < 45) begin
				request_backlog.push_back(any_request(OP_RANGE));
				k++;
			end else if (r < 97) begin
				request_backlog.push_back(random_msg());
				k++;
			end else begin
				request_backlog.push_back(any_request(OP_SPARE));
				k++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.opcode = '0;
		in_ch.range_sample = '0;
		in_ch.pan_dir_char = '0;
		in_ch.pan_hundreds = '0;
		in_ch.pan_tens = '0;
		in_ch.pan_units = '0;
		in_ch.tilt_dir_char = '0;
		in_ch.tilt_hundreds = '0;
		in_ch.tilt_tens = '0;
		in_ch.tilt_units = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		gap_left = 0;
		stall_left = 0;
		mismatches = 0;
		cycles = 0;
		calm = 1'b0;

		// reset state of the tracker
		tilt_center_r = 320;
		pan_center_r = 250;
		tilt_min_r = 300;
		tilt_max_r = 340;
		pan_min_r = 180;
		pan_max_r = 320;
		timeout_r = 200000;
		deadband_r = 10;
		tilt_now = 320;
		pan_now = 250;
		idle_ticks = '0;
		tilt_step_div = 9;
		pan_step_div = 6;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: full offsets, caps, deadband edge, raw bytes, range corners
		request_backlog.push_back(any_request(OP_TICK));
		request_backlog.push_back(msg_of("r500u500"));
		request_backlog.push_back(msg_of("l500d500"));
		request_backlog.push_back(msg_of("l999d999"));
		request_backlog.push_back(msg_of("x009y009"));
		request_backlog.push_back(msg_of("x010y010"));
		request_backlog.push_back(msg_of({8{8'h00}}));
		request_backlog.push_back(msg_of({8{8'hFF}}));
		request_backlog.push_back(range_of(0));
		request_backlog.push_back(msg_of("r123u045"));
		request_backlog.push_back(range_of(4095));
		request_backlog.push_back(msg_of("r123u045"));
		request_backlog.push_back(range_of(1722));
		request_backlog.push_back(msg_of("l250d250"));
		request_backlog.push_back(range_of(1723));
		request_backlog.push_back(msg_of("R050U050"));
		request_backlog.push_back(range_of(12'h555));
		request_backlog.push_back(range_of(12'hAAA));
		request_backlog.push_back(any_request(OP_SPARE));
		request_backlog.push_back(any_request(OP_TICK));
		request_backlog.push_back(any_request(OP_TICK));
		queue_random(250);
		settle();

		// widest limits, zero timeout and deadband
		set_regs(0, 4095, 0, 4095, 0, 4095, 0, 0);
		queue_random(PHASE_ITEMS);
		settle();

		// min above max, full deadband, no idling at all
		calm = 1'b1;
		set_regs(2000, 100, 3000, 1000, 500, 400, 7, 500);
		queue_random(PHASE_ITEMS);
		settle();
		calm = 1'b0;

		// largest timeout, narrow limits at the top and bottom
		set_regs(4095, 0, 4000, 4095, 0, 60, 24'hFFFFFF, 255);
		queue_random(PHASE_ITEMS);
		settle();

		set_random_regs(60);
		queue_random(PHASE_ITEMS);
		settle();

		calm = 1'b1;
		set_random_regs(60);
		queue_random(PHASE_ITEMS);
		settle();
		calm = 1'b0;

		set_random_regs(500);
		queue_random(PHASE_ITEMS);
		settle();

		if (expected_pulses.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
